// ----- hdl/ssc_pkg.sv -----
// Shared constants and types for the stack sequence checker.
package ssc_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int VAL_W      = 11;
  localparam int NXT_W      = VAL_W + 1;
  localparam int DEP_W      = $clog2(MAX_LENGTH + 1);

  localparam logic [VAL_W-1:0] LEN_RESET = VAL_W'(1024);

  typedef enum logic {
    ST_IDLE,
    ST_PUSH
  } ssc_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ssc_shift_t;

endpackage

// ----- hdl/ssc_in_if.sv -----
// Target channel: valid/ready handshake carrying one target beat.
interface ssc_in_if;
  import ssc_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] target;
  logic             last;

  modport source (output valid, output target, output last, input ready);
  modport sink   (input valid, input target, input last, output ready);
endinterface

// ----- hdl/ssc_out_if.sv -----
// Result channel: valid/ready handshake carrying one result beat.
interface ssc_out_if;
  import ssc_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] push_count;
  logic             popped;
  logic             failed;
  logic             sequence_ok;

  modport source (output valid, output push_count, output popped, output failed,
                  output sequence_ok, input ready);
  modport sink   (input valid, input push_count, input popped, input failed,
                  input sequence_ok, output ready);
endinterface

// ----- hdl/ssc_cell.sv -----
// One stack cell: load from the upper neighbor on push, from the lower on pop.
module ssc_cell (
  input  logic                    clk,
  input  ssc_pkg::ssc_shift_t     ctl,
  input  logic [ssc_pkg::VAL_W-1:0] prev_val,
  input  logic [ssc_pkg::VAL_W-1:0] next_val,
  output logic [ssc_pkg::VAL_W-1:0] val
);
  import ssc_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.push) begin
      val_nxt = prev_val;
    end else if (ctl.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
endmodule

// ----- hdl/ssc_stack.sv -----
// Shift stack built from a row of cells; cell 0 is the top.
module ssc_stack (
  input  logic                      clk,
  input  ssc_pkg::ssc_shift_t       ctl,
  input  logic [ssc_pkg::VAL_W-1:0] push_val,
  output logic [ssc_pkg::VAL_W-1:0] top_val
);
  import ssc_pkg::*;

  logic [VAL_W-1:0] cell_val [MAX_LENGTH];

  for (genvar i = 0; i < MAX_LENGTH; i++) begin : g_cell
    logic [VAL_W-1:0] from_prev;
    logic [VAL_W-1:0] from_next;

    if (i == 0) begin : g_top
      assign from_prev = push_val;
    end else begin : g_mid
      assign from_prev = cell_val[i-1];
    end

    if (i == MAX_LENGTH - 1) begin : g_bot
      assign from_next = '0;
    end else begin : g_up
      assign from_next = cell_val[i+1];
    end

    ssc_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .prev_val (from_prev),
      .next_val (from_next),
      .val      (cell_val[i])
    );
  end

  assign top_val = cell_val[0];
endmodule

// ----- hdl/stack_sequence_checker.sv -----
// Top level of the stack sequence checker: control, result register and cell stack.
//
// Each target beat decides at once whether the target can be produced from a
// stack fed with 1..n in ascending order, and its result beat is loaded into
// the output register in the same cycle it is accepted. A target that needs
// k values pushed below it keeps the target channel stalled in ST_PUSH while
// the cell row shifts in the remaining values one per cycle; the first value
// goes in during the accept cycle and a pop does not stall the channel. The
// stack is a row of MAX_LENGTH shift cells with the top in cell 0, so push and
// pop are shifts of the whole row and no clearing pass is needed after reset.
// The failure flag is sticky until the last beat of a sequence, which returns
// the stack, next value and flag to their start state; a last beat skips any
// pending pushes since the stack is discarded anyway. The user must write
// sequence_length through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. The stored length survives the end of
// a sequence, and its effective value saturates at MAX_LENGTH.
module stack_sequence_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  ssc_in_if.sink                    in_if,
  ssc_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [ssc_pkg::VAL_W-1:0] cfg_wdata
);
  import ssc_pkg::*;

  // Control state
  ssc_state_t       state_r, state_nxt;
  logic [DEP_W-1:0] depth_r, depth_nxt;
  logic [NXT_W-1:0] next_r, next_nxt;
  logic             fail_r, fail_nxt;
  logic [VAL_W-1:0] len_r;
  logic [VAL_W-1:0] push_val_r, push_val_nxt;
  logic [VAL_W-1:0] push_end_r, push_end_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_count_r, out_count_nxt;
  logic             out_popped_r, out_popped_nxt;
  logic             out_failed_r, out_failed_nxt;
  logic             out_ok_r, out_ok_nxt;

  // Decision signals for the beat being accepted
  logic             fire;
  logic [VAL_W-1:0] n_eff;
  logic [NXT_W-1:0] tgt_ext;
  logic [NXT_W-1:0] n_push;
  logic             dec_push, dec_pop, dec_fail;
  logic [VAL_W-1:0] top_val;
  ssc_shift_t       shift;
  logic [VAL_W-1:0] stack_in;

  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign fire        = in_if.valid && in_if.ready;

  assign n_eff   = (32'(len_r) > MAX_LENGTH) ? VAL_W'(MAX_LENGTH) : len_r;
  assign tgt_ext = NXT_W'(in_if.target);
  assign n_push  = tgt_ext - next_r;

  // Classify the target: out of range, push path, pop path or mismatch.
  always_comb begin
    dec_push = 1'b0;
    dec_pop  = 1'b0;
    dec_fail = 1'b0;
    if (!fail_r) begin
      if (in_if.target == '0 || in_if.target > n_eff) begin
        dec_fail = 1'b1;
      end else if (tgt_ext >= next_r) begin
        dec_push = 1'b1;
      end else if (depth_r != '0 && top_val == in_if.target) begin
        dec_pop = 1'b1;
      end else begin
        dec_fail = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    next_nxt       = next_r;
    fail_nxt       = fail_r;
    push_val_nxt   = push_val_r;
    push_end_nxt   = push_end_r;
    out_valid_nxt  = out_valid_r;
    out_count_nxt  = out_count_r;
    out_popped_nxt = out_popped_r;
    out_failed_nxt = out_failed_r;
    out_ok_nxt     = out_ok_r;
    shift          = '0;
    stack_in       = push_val_r;

    // Drop the result once taken; a new beat below reloads it.
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          if (dec_fail) begin
            fail_nxt = 1'b1;
          end
          if (dec_push) begin
            depth_nxt = depth_r + DEP_W'(n_push);
            next_nxt  = tgt_ext + NXT_W'(1);
          end
          if (dec_pop) begin
            depth_nxt = depth_r - DEP_W'(1);
          end

          out_valid_nxt  = 1'b1;
          out_count_nxt  = dec_push ? VAL_W'(n_push + NXT_W'(1)) : '0;
          out_popped_nxt = dec_push || dec_pop;
          out_failed_nxt = fail_r || dec_fail;
          out_ok_nxt     = in_if.last && !(fail_r || dec_fail) && depth_nxt == '0 &&
                           next_nxt == NXT_W'(n_eff) + NXT_W'(1);

          if (in_if.last) begin
            // End of sequence: restart, skip any pending stack work.
            depth_nxt = '0;
            next_nxt  = NXT_W'(1);
            fail_nxt  = 1'b0;
          end else begin
            if (dec_pop) begin
              shift.pop = 1'b1;
            end
            if (dec_push && n_push != '0) begin
              // Push the first value now, the rest one per cycle.
              shift.push = 1'b1;
              stack_in   = VAL_W'(next_r);
              if (n_push != NXT_W'(1)) begin
                state_nxt    = ST_PUSH;
                push_val_nxt = VAL_W'(next_r + NXT_W'(1));
                push_end_nxt = in_if.target - VAL_W'(1);
              end
            end
          end
        end
      end
      ST_PUSH: begin
        shift.push   = 1'b1;
        stack_in     = push_val_r;
        push_val_nxt = push_val_r + VAL_W'(1);
        if (push_val_r == push_end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      next_r      <= NXT_W'(1);
      fail_r      <= 1'b0;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      next_r      <= next_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    push_val_r   <= push_val_nxt;
    push_end_r   <= push_end_nxt;
    out_count_r  <= out_count_nxt;
    out_popped_r <= out_popped_nxt;
    out_failed_r <= out_failed_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  ssc_stack u_stack (
    .clk      (clk),
    .ctl      (shift),
    .push_val (stack_in),
    .top_val  (top_val)
  );

  assign out_if.valid       = out_valid_r;
  assign out_if.push_count  = out_count_r;
  assign out_if.popped      = out_popped_r;
  assign out_if.failed      = out_failed_r;
  assign out_if.sequence_ok = out_ok_r;
endmodule

// ----- hdl/ssc_checker.sv -----
// Port-level assertions for the stack sequence checker, bound to the top level.
module ssc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ssc_pkg::VAL_W-1:0] push_count,
  input logic                      popped,
  input logic                      failed,
  input logic                      sequence_ok
);
  import ssc_pkg::*;

  // A stalled result beat holds its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(push_count) && $stable(popped) &&
    $stable(failed) && $stable(sequence_ok))
    else $error("result beat changed while stalled");

  // A pop never comes with the failure flag.
  a_pop_no_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && popped |-> !failed)
    else $error("popped together with failed");

  // Pushes always end in popping the target.
  a_push_pops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && push_count != '0 |-> popped)
    else $error("pushes reported without a pop");

  // Success needs a clean final pop.
  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sequence_ok |-> popped && !failed)
    else $error("sequence_ok without a clean pop");

  // No result beat right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind stack_sequence_checker ssc_checker u_ssc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .push_count  (out_if.push_count),
  .popped      (out_if.popped),
  .failed      (out_if.failed),
  .sequence_ok (out_if.sequence_ok)
);

// ----- tb/tb_stack_sequence_checker.sv -----
// Self-checking testbench for the stack sequence checker: directed table, then random sequences.
`timescale 1ns / 100ps

module tb_stack_sequence_checker;
  import ssc_pkg::*;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [VAL_W-1:0] push_count;
    logic             popped;
    logic             failed;
    logic             sequence_ok;
  } result_t;

  // Directed table: a row is either a target beat or a length write.
  typedef enum logic {
    ROW_BEAT,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [VAL_W-1:0] value;
    logic             lst;
    bit               typed;
    result_t          res;
  } plan_row_t;

  // Ways to spoil an otherwise legal target order.
  typedef enum int {
    MUT_VALUE,
    MUT_DUP,
    MUT_SWAP,
    MUT_TRUNC,
    MUT_EXTRA
  } mutation_t;

  localparam int      SETTLE_CYCLES   = MAX_LENGTH + 8;
  localparam int      SINK_HOLD       = 400;
  localparam int      ITEMS_PER_PHASE = 64;
  localparam int      NUM_PHASES      = 12;
  localparam longint  TIMEOUT_NS      = 64'd50_000_000;
  localparam result_t R_FAIL          = '{11'd0, 1'b0, 1'b1, 1'b0};

  logic clk = 1'b0;
  logic rst_n;
  logic             cfg_we;
  logic [VAL_W-1:0] cfg_wdata;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  stack_sequence_checker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: stack contents, next value to push, sticky failure
  // and the programmed length. Updated once per accepted target beat.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] shadow_stack [MAX_LENGTH];
  int               shadow_depth = 0;
  int               shadow_next  = 1;
  bit               shadow_fail  = 1'b0;
  logic [VAL_W-1:0] shadow_len   = LEN_RESET;

  result_t          pending_results [$];   // results still owed by the block
  logic [VAL_W-1:0] target_order [$];      // targets of the sequence being built
  int               mismatches    = 0;
  bit               src_calm      = 1'b0;  // sender runs without gaps while set
  bit               hold_sink_req = 1'b0;  // ask the receiver for one long stall

  plan_row_t directed_plan [25] = '{
    // Length is 1024 out of reset.
    '{ROW_BEAT, 11'd0,    1'b0, 1'b1, R_FAIL},                          // zero target
    '{ROW_BEAT, 11'd5,    1'b1, 1'b1, R_FAIL},                          // already failed
    '{ROW_BEAT, 11'd1024, 1'b0, 1'b1, '{11'd1024, 1'b1, 1'b0, 1'b0}},   // deepest push
    '{ROW_BEAT, 11'd1023, 1'b0, 1'b1, '{11'd0, 1'b1, 1'b0, 1'b0}},      // pop from top
    '{ROW_BEAT, 11'd1,    1'b1, 1'b1, R_FAIL},                          // buried target
    '{ROW_BEAT, 11'd1025, 1'b0, 1'b1, R_FAIL},                          // above length
    '{ROW_BEAT, 11'd2047, 1'b1, 1'b1, R_FAIL},
    '{ROW_CFG,  11'd3,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd2,    1'b0, 1'b1, '{11'd2, 1'b1, 1'b0, 1'b0}},
    '{ROW_BEAT, 11'd3,    1'b0, 1'b1, '{11'd1, 1'b1, 1'b0, 1'b0}},
    '{ROW_BEAT, 11'd1,    1'b1, 1'b1, '{11'd0, 1'b1, 1'b0, 1'b1}},      // legal sequence
    '{ROW_BEAT, 11'd1,    1'b0, 1'b1, '{11'd1, 1'b1, 1'b0, 1'b0}},
    '{ROW_BEAT, 11'd1,    1'b0, 1'b1, R_FAIL},                          // duplicate
    '{ROW_BEAT, 11'd2,    1'b1, 1'b1, R_FAIL},
    '{ROW_BEAT, 11'd3,    1'b1, 1'b1, '{11'd3, 1'b1, 1'b0, 1'b0}},      // too few targets
    '{ROW_BEAT, 11'd3,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd2,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd1,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd1,    1'b1, 1'b0, '0},                              // too many targets
    '{ROW_CFG,  11'd0,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd1,    1'b1, 1'b1, R_FAIL},                          // zero length
    '{ROW_CFG,  11'd2047, 1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd1024, 1'b1, 1'b0, '0},                              // saturated length
    '{ROW_CFG,  11'd1,    1'b0, 1'b0, '0},
    '{ROW_BEAT, 11'd1,    1'b1, 1'b1, '{11'd1, 1'b1, 1'b0, 1'b1}}
  };

  // Lengths for the random phases: extremes, zero, saturating and small ones.
  int unsigned phase_lens [NUM_PHASES] = '{1, 2, 6, 0, 12, 1024, 33, 2047, 4, 1500, 64, 1};

  // Advance the shadow by one target and return the result it must produce.
  function automatic result_t predict_result(input logic [VAL_W-1:0] tgt, input logic lst);
    result_t r;
    int      n;
    int      t;
    r = '0;
    n = (shadow_len > MAX_LENGTH) ? MAX_LENGTH : int'(shadow_len);
    t = int'(tgt);
    if (!shadow_fail) begin
      if (t == 0 || t > n) begin
        shadow_fail = 1'b1;
      end else if (t >= shadow_next) begin
        // Push up to the target; the target itself pops at once.
        r.push_count = VAL_W'(t - shadow_next + 1);
        for (int v = shadow_next; v < t; v++) begin
          shadow_stack[shadow_depth] = VAL_W'(v);
          shadow_depth++;
        end
        shadow_next = t + 1;
        r.popped    = 1'b1;
      end else if (shadow_depth > 0 && shadow_stack[shadow_depth-1] == tgt) begin
        shadow_depth--;
        r.popped = 1'b1;
      end else begin
        shadow_fail = 1'b1;
      end
    end
    r.failed = shadow_fail;
    if (lst) begin
      r.sequence_ok = !shadow_fail && shadow_depth == 0 && shadow_next == n + 1;
      shadow_depth  = 0;
      shadow_next   = 1;
      shadow_fail   = 1'b0;
    end
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Build a target order that a stack can produce, then maybe spoil it.
  function automatic void build_target_order(input int n);
    int        held [$];
    int        nxt;
    int        push_pct;
    int        pos;
    int        pos2;
    logic [VAL_W-1:0] tmp;
    target_order.delete();
    nxt      = 1;
    push_pct = (n > 64) ? (($urandom_range(0, 1) == 1) ? 99 : 90) : 50;
    while (target_order.size() < n) begin
      if (held.size() == 0 || (nxt <= n && $urandom_range(0, 99) < push_pct)) begin
        held.insert(held.size(), nxt);
        nxt++;
      end else begin
        target_order.insert(target_order.size(), VAL_W'(held.pop_back()));
      end
    end
    // Long sequences are cut short to keep the run fast.
    if (n > 64) begin
      pos = $urandom_range(3, 12);
      while (target_order.size() > pos) void'(target_order.pop_back());
    end
    if ($urandom_range(0, 9) < 3) begin
      pos  = $urandom_range(0, target_order.size() - 1);
      pos2 = $urandom_range(0, target_order.size() - 1);
      case (mutation_t'($urandom_range(0, 4)))
        MUT_VALUE: begin
          target_order[pos] = ($urandom_range(0, 1) == 1) ? VAL_W'($urandom_range(0, 2047))
                                                          : VAL_W'($urandom_range(0, n + 1));
        end
        MUT_DUP: begin
          target_order.insert(pos2, target_order[pos]);
        end
        MUT_SWAP: begin
          tmp                = target_order[pos];
          target_order[pos]  = target_order[pos2];
          target_order[pos2] = tmp;
        end
        MUT_TRUNC: begin
          while (target_order.size() > pos + 1) void'(target_order.pop_back());
        end
        MUT_EXTRA: begin
          target_order.insert(target_order.size(), VAL_W'($urandom_range(1, n)));
        end
        default: ;
      endcase
    end
  endfunction

  // Offer one target beat, hold it until accepted, then record its result.
  task automatic send_beat(input logic [VAL_W-1:0] tgt, input logic lst,
                           input bit typed, input result_t typed_res);
    result_t pred;
    int      gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.target <= tgt;
    in_ch.last   <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // The shadow advances for every beat; typed rows override the prediction.
    pred = predict_result(tgt, lst);
    pending_results.insert(pending_results.size(), typed ? typed_res : pred);
  endtask

  // Drop valid and wait until every owed result has been received.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Drain, then let trailing pushes of the last target finish.
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program the length while the block is idle.
  task automatic write_length(input logic [VAL_W-1:0] len);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_len  = len;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps, calm stretches, and one long stall on request
  // so the result register fills and the target channel backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap_left;
    bit calm;
    gap_left = 0;
    calm     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (hold_sink_req) begin
        hold_sink_req = 1'b0;
        gap_left      = SINK_HOLD;
      end
      if (gap_left > 0) begin
        out_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        out_ch.ready <= 1'b1;
        gap_left = pick_gap(calm);
      end
    end
  end

  // Compare each accepted result beat against the oldest owed result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expected result waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.push_count !== want.push_count) begin
          $error("push_count: expected %0d, got %0d", want.push_count, out_ch.push_count);
          mismatches++;
        end
        if (out_ch.popped !== want.popped) begin
          $error("popped: expected %0b, got %0b", want.popped, out_ch.popped);
          mismatches++;
        end
        if (out_ch.failed !== want.failed) begin
          $error("failed: expected %0b, got %0b", want.failed, out_ch.failed);
          mismatches++;
        end
        if (out_ch.sequence_ok !== want.sequence_ok) begin
          $error("sequence_ok: expected %0b, got %0b", want.sequence_ok, out_ch.sequence_ok);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases at several lengths.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int eff;
    int sent;
    bit paused;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.target <= '0;
    in_ch.last   <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_length(directed_plan[i].value);
      end else begin
        send_beat(directed_plan[i].value, directed_plan[i].lst,
                  directed_plan[i].typed, directed_plan[i].res);
      end
    end

    paused = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_length(VAL_W'(phase_lens[p]));
      eff      = (phase_lens[p] > MAX_LENGTH) ? MAX_LENGTH : int'(phase_lens[p]);
      src_calm = ($urandom_range(0, 3) == 0);
      // Stall the receiver once while targets keep coming.
      if (p == 2) hold_sink_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // Hold the sender once mid-phase until every result is back.
        if (p == 4 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if (eff == 0 || $urandom_range(0, 9) == 0) begin
          send_beat(VAL_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end else begin
          build_target_order(eff);
          foreach (target_order[i]) begin
            send_beat(target_order[i], i == target_order.size() - 1, 1'b0, '0);
          end
          sent += target_order.size();
        end
      end
    end

    settle_block();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
